### src/flr_pkg.sv
// Shared types and constants for the framebuffer line rasterizer.
// Used by flr_line_walker and framebuffer_line_rasterizer_core; no dependencies.
package flr_pkg;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int ERR_W   = 12;
    localparam int ADDR_W  = 24;
    localparam int COLOR_W = 8;

    // Input stream: tdata packs start_x, start_y, end_x, end_y from bit 0 up
    localparam int IN_FIELDS_W = 2 * COL_W + 2 * ROW_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((ADDR_W + COLOR_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_COLOR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BASE = 1'b1;
    localparam int CFG_DATA_W = ADDR_W;

    // Operation codes carried on s_tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] start_x;
        logic [ROW_W-1:0] start_y;
        logic [COL_W-1:0] end_x;
        logic [ROW_W-1:0] end_y;
    } line_cmd_t;

    // Pixel the walker emits for the item now leaving the input register
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } pixel_t;

endpackage

### src/flr_line_walker.sv
// Bresenham walker state: endpoints, spans, directions and error term.
// Depends on flr_pkg for the command and pixel structs.
module flr_line_walker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              op,
    input  flr_pkg::line_cmd_t cmd,
    output flr_pkg::pixel_t    pix
);

    logic [flr_pkg::COL_W-1:0]        cur_col_reg, goal_col_reg, delta_col_reg;
    logic [flr_pkg::ROW_W-1:0]        cur_row_reg, goal_row_reg, delta_row_reg;
    logic                             col_dir_neg_reg, row_dir_neg_reg;
    logic signed [flr_pkg::ERR_W-1:0] error_term_reg;
    logic                             active_reg;

    logic [flr_pkg::COL_W-1:0]        cur_col_next, goal_col_next, delta_col_next;
    logic [flr_pkg::ROW_W-1:0]        cur_row_next, goal_row_next, delta_row_next;
    logic                             col_dir_neg_next, row_dir_neg_next;
    logic signed [flr_pkg::ERR_W-1:0] error_term_next;
    logic                             active_next;

    logic                             at_goal;
    logic signed [flr_pkg::ERR_W:0]   twice;
    logic signed [flr_pkg::ERR_W:0]   neg_drow;
    logic signed [flr_pkg::ERR_W:0]   pos_dcol;
    logic                             step_col, step_row;
    logic signed [flr_pkg::ERR_W-1:0] drow_ext, dcol_ext;
    logic                             load_col_neg, load_row_neg;

    assign at_goal  = (cur_col_reg == goal_col_reg) && (cur_row_reg == goal_row_reg);
    assign twice    = {error_term_reg, 1'b0};
    assign drow_ext = $signed({{(flr_pkg::ERR_W - flr_pkg::ROW_W){1'b0}}, delta_row_reg});
    assign dcol_ext = $signed({{(flr_pkg::ERR_W - flr_pkg::COL_W){1'b0}}, delta_col_reg});
    assign neg_drow = -{drow_ext[flr_pkg::ERR_W-1], drow_ext};
    assign pos_dcol = {dcol_ext[flr_pkg::ERR_W-1], dcol_ext};
    assign step_col = twice >= neg_drow;
    assign step_row = twice <= pos_dcol;

    assign load_col_neg = cmd.end_x < cmd.start_x;
    assign load_row_neg = cmd.end_y < cmd.start_y;

    assign pix.valid = (op == flr_pkg::OP_STEP) && active_reg;
    assign pix.col   = cur_col_reg;
    assign pix.row   = cur_row_reg;
    assign pix.last  = at_goal;

    always_comb
    begin
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        goal_col_next    = goal_col_reg;
        goal_row_next    = goal_row_reg;
        delta_col_next   = delta_col_reg;
        delta_row_next   = delta_row_reg;
        col_dir_neg_next = col_dir_neg_reg;
        row_dir_neg_next = row_dir_neg_reg;
        error_term_next  = error_term_reg;
        active_next      = active_reg;
        if (advance)
        begin
            if (op == flr_pkg::OP_LOAD)
            begin
                cur_col_next     = cmd.start_x;
                cur_row_next     = cmd.start_y;
                goal_col_next    = cmd.end_x;
                goal_row_next    = cmd.end_y;
                col_dir_neg_next = load_col_neg;
                row_dir_neg_next = load_row_neg;
                delta_col_next   = load_col_neg ? cmd.start_x - cmd.end_x
                                                : cmd.end_x - cmd.start_x;
                delta_row_next   = load_row_neg ? cmd.start_y - cmd.end_y
                                                : cmd.end_y - cmd.start_y;
                error_term_next  =
                    $signed({{(flr_pkg::ERR_W - flr_pkg::COL_W){1'b0}}, delta_col_next})
                  - $signed({{(flr_pkg::ERR_W - flr_pkg::ROW_W){1'b0}}, delta_row_next});
                active_next      = 1'b1;
            end
            else if (active_reg)
            begin
                if (at_goal)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    if (step_col)
                    begin
                        cur_col_next = col_dir_neg_reg ? cur_col_reg - 1'b1
                                                       : cur_col_reg + 1'b1;
                    end
                    if (step_row)
                    begin
                        cur_row_next = row_dir_neg_reg ? cur_row_reg - 1'b1
                                                       : cur_row_reg + 1'b1;
                    end
                    error_term_next = error_term_reg
                                    - (step_col ? drow_ext : '0)
                                    + (step_row ? dcol_ext : '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            goal_col_reg    <= '0;
            goal_row_reg    <= '0;
            delta_col_reg   <= '0;
            delta_row_reg   <= '0;
            col_dir_neg_reg <= 1'b0;
            row_dir_neg_reg <= 1'b0;
            error_term_reg  <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            goal_col_reg    <= goal_col_next;
            goal_row_reg    <= goal_row_next;
            delta_col_reg   <= delta_col_next;
            delta_row_reg   <= delta_row_next;
            col_dir_neg_reg <= col_dir_neg_next;
            row_dir_neg_reg <= row_dir_neg_next;
            error_term_reg  <= error_term_next;
            active_reg      <= active_next;
        end
    end

    // A line only starts from a load
    a_active_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> $past(advance && op == flr_pkg::OP_LOAD))
        else $error("walker went active without a load");

    // The end point closes the line unless a load replaces it
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pix.valid && pix.last |=> !active_reg)
        else $error("walker still active after the last pixel");

endmodule

### src/framebuffer_line_rasterizer_core.sv
// Line rasterizer: accepts one load or step item per cycle and emits pixel writes at the
// rate of one per cycle, as long as m_tready does not stall the output. An accepted item
// lands in an input register; when it advances it updates the Bresenham walker and its
// pixel, if any, is captured in the output register. Throughput is one item per cycle
// without back-pressure, limited by the combinational error update and row*width+col
// address add. While a result waits in the output register the input register takes
// one more item and then holds s_tready low until the result is taken.
// Depends on flr_pkg and flr_line_walker.
module framebuffer_line_rasterizer_core
#(
    parameter int SCREEN_WIDTH = 640
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [flr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [flr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Command stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x[9:0], start_y[18:10], end_x[28:19], end_y[37:29], zero pad
    input  logic [flr_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  logic                              s_tuser,
    // Pixel write stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_address[23:0], pixel_value[31:24]
    output logic [flr_pkg::OUT_DATA_W-1:0]    m_tdata,
    // last_pixel
    output logic                              m_tlast
);

    localparam int WIDTH_BITS = $clog2(SCREEN_WIDTH + 1);
    localparam int OFFSET_W   = flr_pkg::ROW_W + WIDTH_BITS;

    logic [flr_pkg::COLOR_W-1:0]      draw_color_reg;
    logic [flr_pkg::ADDR_W-1:0]       frame_base_reg;

    logic                             in_valid_reg;
    logic                             in_op_reg;
    flr_pkg::line_cmd_t               in_cmd_reg;

    logic                             out_valid_reg, out_valid_next;
    logic [flr_pkg::ADDR_W-1:0]       out_addr_reg, out_addr_next;
    logic [flr_pkg::COLOR_W-1:0]      out_value_reg;
    logic                             out_last_reg;

    logic                             advance;
    flr_pkg::pixel_t                  pix;
    logic [OFFSET_W-1:0]              row_offset;
    flr_pkg::line_cmd_t               s_cmd;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    assign s_cmd.start_x = s_tdata[9:0];
    assign s_cmd.start_y = s_tdata[18:10];
    assign s_cmd.end_x   = s_tdata[28:19];
    assign s_cmd.end_y   = s_tdata[37:29];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg <= '0;
            frame_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                flr_pkg::CFG_DRAW_COLOR: draw_color_reg <= cfg_data[flr_pkg::COLOR_W-1:0];
                flr_pkg::CFG_FRAME_BASE: frame_base_reg <= cfg_data;
            endcase
        end
    end

    // Input register: load on transfer, drop once consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= s_tuser;
            in_cmd_reg <= s_cmd;
        end
    end

    flr_line_walker u_walker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .op      (in_op_reg),
        .cmd     (in_cmd_reg),
        .pix     (pix)
    );

    assign row_offset    = pix.row * WIDTH_BITS'(SCREEN_WIDTH);
    assign out_addr_next = frame_base_reg
                         + flr_pkg::ADDR_W'(row_offset)
                         + flr_pkg::ADDR_W'(pix.col);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = pix.valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pix.valid)
        begin
            out_addr_reg  <= out_addr_next;
            out_value_reg <= draw_color_reg;
            out_last_reg  <= pix.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(flr_pkg::OUT_DATA_W - flr_pkg::ADDR_W - flr_pkg::COLOR_W){1'b0}},
                       out_value_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

    // A load never produces a pixel
    a_load_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_op_reg == flr_pkg::OP_LOAD |=> !m_tvalid)
        else $error("pixel emitted for a load item");

    // A new result only comes from an item leaving the input register
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && pix.valid))
        else $error("result without a consumed step item");

    // Backpressure only with a held item
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room downstream");

endmodule
